[hw/rtl/oal_pkg.sv]
`default_nettype none
package oal_pkg;

  localparam int DEPTH = 64;
  localparam int KEY_W = 32;
  localparam int POS_W = 7;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Shift command broadcast to every cell.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
    logic [CNT_W-1:0] cnt;
  } cell_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/oal_cell.sv]
`default_nettype none
module oal_cell (
  input  wire logic                      clk,
  input  wire logic [oal_pkg::IDX_W-1:0] cell_idx,
  input  wire oal_pkg::cell_ctl_t        ctl,
  input  wire logic [oal_pkg::KEY_W-1:0] key,
  input  wire logic [oal_pkg::KEY_W-1:0] lo_ent,
  input  wire logic [oal_pkg::KEY_W-1:0] hi_ent,
  output logic [oal_pkg::KEY_W-1:0]      ent,
  output logic                           hit
);
  import oal_pkg::*;

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  logic             hit_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (cell_idx > ctl.at) begin
        entry_nxt = lo_ent;
      end else if (cell_idx == ctl.at) begin
        entry_nxt = key;
      end
    end
    if (ctl.del && (cell_idx >= ctl.at)) begin
      entry_nxt = hi_ent;
    end
  end

  // Match only counts for entries below the fill count.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= (entry_r == key) && (CNT_W'(cell_idx) < ctl.cnt);
  end

  assign ent = entry_r;
  assign hit = hit_r;

endmodule
`default_nettype wire

[hw/rtl/oal_pick.sv]
`default_nettype none
module oal_pick (
  input  wire logic                      clk,
  input  wire logic [oal_pkg::DEPTH-1:0] hits,
  output logic                           found,
  output logic [oal_pkg::IDX_W-1:0]      first
);
  import oal_pkg::*;

  logic             found_r;
  logic [IDX_W-1:0] first_r;
  logic [IDX_W-1:0] first_nxt;

  // Lowest set bit wins.
  always_comb begin
    first_nxt = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first_nxt = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= |hits;
    first_r <= first_nxt;
  end

  assign found = found_r;
  assign first = first_r;

endmodule
`default_nettype wire

[hw/rtl/ordered_array_list_core.sv]
`default_nettype none
// Channel | Dir | Payload
// in_     | in  | tuser: kind[1:0]; tdata: key[31:0], position[38:32], zero pad
// out_    | out | tdata: ok[0], index[6:1], count[13:7], zero pad
//
// One item at a time. Search and delete pass from transfer to the result
// register via latch, compare in every cell, pick first hit and shift/report;
// insert and clear skip compare and pick. All cells shift in the same cycle.
// A waiting result does not block the next transfer in; the item holds in its
// last step until the output register frees. Reset clears the count and the
// control state; stored entries stay undefined until written.
module ordered_array_list_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // kind
  input  wire logic [39:0] in_tdata,   // key, position, pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // ok, index, count, pad
);
  import oal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_FIND  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  kind_t                   kind_r;
  logic signed [KEY_W-1:0] key_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        used_r, used_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [15:0]             out_data_r, out_data_nxt;

  logic [KEY_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0] hits;
  logic             found;
  logic [IDX_W-1:0] first;
  cell_ctl_t        ctl;

  logic             in_fire;
  logic             fire;
  logic             ins_ok;
  logic             res_ok;
  logic [IDX_W-1:0] res_idx;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // Finish an item only when the output register can take the result.
  assign fire      = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  assign ins_ok    = (used_r < CNT_W'(DEPTH)) && (CMP_W'(pos_r) <= CMP_W'(used_r));

  // Broadcast shift command to the cell row.
  always_comb begin
    ctl.ins = fire && (kind_r == KIND_INSERT) && ins_ok;
    ctl.del = fire && (kind_r == KIND_DELETE) && found;
    ctl.at  = (kind_r == KIND_INSERT) ? IDX_W'(pos_r) : first;
    ctl.cnt = used_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_W-1:0] lo_ent;
      logic [KEY_W-1:0] hi_ent;
      if (gi == 0) begin : g_first
        assign lo_ent = key_r;
      end else begin : g_lo
        assign lo_ent = ent[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign hi_ent = ent[gi];
      end else begin : g_hi
        assign hi_ent = ent[gi+1];
      end
      oal_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(gi)),
        .ctl      (ctl),
        .key      (key_r),
        .lo_ent   (lo_ent),
        .hi_ent   (hi_ent),
        .ent      (ent[gi]),
        .hit      (hits[gi])
      );
    end
  endgenerate

  oal_pick u_pick (
    .clk   (clk),
    .hits  (hits),
    .found (found),
    .first (first)
  );

  // Result of the item in its last step.
  always_comb begin
    res_ok   = 1'b0;
    res_idx  = '0;
    used_nxt = used_r;
    case (kind_r)
      KIND_SEARCH: begin
        res_ok  = found;
        res_idx = found ? first : '0;
      end
      KIND_INSERT: begin
        res_ok  = ins_ok;
        res_idx = ins_ok ? IDX_W'(pos_r) : '0;
        if (ins_ok) begin
          used_nxt = used_r + CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        res_ok  = found;
        res_idx = found ? first : '0;
        if (found) begin
          used_nxt = used_r - CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        res_ok   = 1'b1;
        used_nxt = '0;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    out_data_nxt = {2'b00, OUT_CNT_W'(used_nxt), OUT_IDX_W'(res_idx), res_ok};
  end

  // Sequence: search and delete need the compare and pick steps.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((kind_t'(in_tuser) == KIND_SEARCH) || (kind_t'(in_tuser) == KIND_DELETE)) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_CMP:   state_nxt = S_FIND;
      S_FIND:  state_nxt = S_APPLY;
      S_APPLY: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        used_r <= used_nxt;
      end
    end
  end

  // Payload holds: latch the item on transfer, the result on finish.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= kind_t'(in_tuser);
      key_r  <= in_tdata[KEY_W-1:0];
      pos_r  <= in_tdata[KEY_W+POS_W-1:KEY_W];
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
